### hw/rtl/fa_pkg.sv
package fa_pkg;

    // Fixed widths of the port fields.
    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_SUB   = 3'd2,
        CMD_MUL   = 3'd3,
        CMD_DIV   = 3'd4,
        CMD_RECIP = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_OVF  = 2'd2
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_FIN_OPER,
        OP_GCD_START,
        OP_DIV_START,
        OP_OPER_WB,
        OP_FIN_EQ,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_DD,
        OP_SUM,
        OP_MUL_NN,
        OP_MUL_ND,
        OP_MUL_DN,
        OP_FIN_Q,
        OP_COMMIT,
        OP_RECIP,
        OP_ZERO_ERR,
        OP_NOP_DONE
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RED_GSTART,
        S_RED_GWAIT,
        S_RED_DWAIT,
        S_SETUP,
        S_MUL_B,
        S_MUL_DD,
        S_SUM,
        S_MUL_DN,
        S_FIN_GSTART,
        S_FIN_GWAIT,
        S_FIN_DWAIT,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             d2_zero;
        logic             n2_zero;
        logic             den_eq;
        logic             acc_num_zero;
        logic             gcd_done;
        logic             div_done;
    } dp_stat_t;

endpackage

### hw/rtl/fa_gcd.sv
module fa_gcd #(
    parameter int DW = 2 * fa_pkg::WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] a_in,
    input  logic [DW-1:0] b_in,
    output logic [DW-1:0] g,
    output logic          done
);

    localparam int KW = $clog2(DW);

    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [DW-1:0] g_reg, g_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    // Binary gcd, one shift or subtract per cycle.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0 || b_reg == '0)
            begin
                g_next    = (a_reg | b_reg) << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_next = (b_reg - a_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign g    = g_reg;
    assign done = done_reg;

endmodule

### hw/rtl/fa_div.sv
module fa_div #(
    parameter int DW = 2 * fa_pkg::WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, divisor};

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### hw/rtl/fa_dp.sv
module fa_dp #(
    parameter int WIDTH = fa_pkg::WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fa_pkg::op_t                   op,
    input  logic [fa_pkg::CMD_W-1:0]      cmd,
    input  logic [fa_pkg::FIELD_W-1:0]    operand_num,
    input  logic [fa_pkg::FIELD_W-1:0]    operand_den,
    output logic signed [fa_pkg::FIELD_W-1:0] result_num,
    output logic signed [fa_pkg::FIELD_W-1:0] result_den,
    output logic [fa_pkg::STATUS_W-1:0]   status,
    output logic                          done,
    output fa_pkg::dp_stat_t              stat
);

    localparam int PW = 2 * WIDTH;

    logic signed [WIDTH-1:0] acc_num_reg, acc_num_next;
    logic signed [WIDTH-1:0] acc_den_reg, acc_den_next;
    logic [fa_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic             opn_neg_reg, opn_neg_next;
    logic [WIDTH-1:0] opn_mag_reg, opn_mag_next;
    logic             opd_neg_reg, opd_neg_next;
    logic [WIDTH-1:0] opd_mag_reg, opd_mag_next;
    logic             nn_reg, nn_next;
    logic [PW-1:0]    nm_reg, nm_next;
    logic             dn_reg, dn_next;
    logic [PW-1:0]    dm_reg, dm_next;
    logic [PW-1:0]    pa_reg, pa_next;
    logic [PW-1:0]    pb_reg, pb_next;
    logic signed [fa_pkg::FIELD_W-1:0] result_num_reg, result_num_next;
    logic signed [fa_pkg::FIELD_W-1:0] result_den_reg, result_den_next;
    fa_pkg::status_t  status_reg, status_next;
    logic             done_reg, done_next;

    logic             n1_neg, d1_neg;
    logic [WIDTH-1:0] n1_mag, d1_mag;
    logic [WIDTH-1:0] in_n, in_d;
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [PW-1:0]    mul_p;
    logic             is_sub, neg_on, neg_a, neg_b;
    logic signed [WIDTH:0] n1x, n2s, s_val;
    logic [WIDTH:0]   s_mag;
    logic [WIDTH-1:0] d2s;
    logic [PW-1:0]    lim;
    logic             fit_n, fit_d;
    logic [PW-1:0]    g_val, qn, qd;
    logic             gcd_done, div_done, div_done_d;

    assign n1_neg = acc_num_reg[WIDTH-1];
    assign d1_neg = acc_den_reg[WIDTH-1];
    assign n1_mag = n1_neg ? -acc_num_reg : acc_num_reg;
    assign d1_mag = d1_neg ? -acc_den_reg : acc_den_reg;
    assign in_n   = operand_num[WIDTH-1:0];
    assign in_d   = operand_den[WIDTH-1:0];

    // Single shared multiplier; its product always lands in a register.
    always_comb
    begin
        case (op)
            fa_pkg::OP_MUL_A:  begin mul_a = n1_mag; mul_b = opd_mag_reg; end
            fa_pkg::OP_MUL_B:  begin mul_a = opn_mag_reg; mul_b = d1_mag; end
            fa_pkg::OP_MUL_DD: begin mul_a = d1_mag; mul_b = opd_mag_reg; end
            fa_pkg::OP_MUL_NN: begin mul_a = n1_mag; mul_b = opn_mag_reg; end
            fa_pkg::OP_MUL_ND: begin mul_a = n1_mag; mul_b = opd_mag_reg; end
            fa_pkg::OP_MUL_DN: begin mul_a = d1_mag; mul_b = opn_mag_reg; end
            default:           begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Signs of the two cross products; a zero product counts as positive.
    assign is_sub = (cmd_reg == fa_pkg::CMD_SUB);
    assign neg_on = opn_neg_reg ^ is_sub;
    assign neg_a  = (n1_mag != '0) && (n1_neg ^ opd_neg_reg);
    assign neg_b  = (opn_mag_reg != '0) && (neg_on ^ d1_neg);

    // Equal-denominator path works on the numerators directly.
    assign n1x   = (WIDTH+1)'(acc_num_reg);
    assign n2s   = opn_neg_reg ? -$signed({1'b0, opn_mag_reg}) : $signed({1'b0, opn_mag_reg});
    assign s_val = is_sub ? n1x - n2s : n1x + n2s;
    assign s_mag = s_val[WIDTH] ? -s_val : s_val;
    assign d2s   = opd_neg_reg ? -opd_mag_reg : opd_mag_reg;

    assign lim   = PW'(1) << (WIDTH - 1);
    assign fit_n = nn_reg ? (nm_reg <= lim) : (nm_reg < lim);
    assign fit_d = dn_reg ? (dm_reg <= lim) : (dm_reg < lim);

    fa_gcd #(.DW(PW)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op == fa_pkg::OP_GCD_START),
        .a_in  (nm_reg),
        .b_in  (dm_reg),
        .g     (g_val),
        .done  (gcd_done)
    );

    fa_div #(.DW(PW)) u_div_num (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == fa_pkg::OP_DIV_START),
        .dividend (nm_reg),
        .divisor  (g_val),
        .quotient (qn),
        .done     (div_done)
    );

    fa_div #(.DW(PW)) u_div_den (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == fa_pkg::OP_DIV_START),
        .dividend (dm_reg),
        .divisor  (g_val),
        .quotient (qd),
        .done     (div_done_d)
    );

    always_comb
    begin
        acc_num_next    = acc_num_reg;
        acc_den_next    = acc_den_reg;
        cmd_next        = cmd_reg;
        opn_neg_next    = opn_neg_reg;
        opn_mag_next    = opn_mag_reg;
        opd_neg_next    = opd_neg_reg;
        opd_mag_next    = opd_mag_reg;
        nn_next         = nn_reg;
        nm_next         = nm_reg;
        dn_next         = dn_reg;
        dm_next         = dm_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        result_num_next = result_num_reg;
        result_den_next = result_den_reg;
        status_next     = status_reg;
        done_next       = 1'b0;
        case (op)
            fa_pkg::OP_CAPTURE:
            begin
                cmd_next     = cmd;
                opn_neg_next = in_n[WIDTH-1];
                opn_mag_next = in_n[WIDTH-1] ? -in_n : in_n;
                opd_neg_next = in_d[WIDTH-1];
                opd_mag_next = in_d[WIDTH-1] ? -in_d : in_d;
            end
            fa_pkg::OP_FIN_OPER:
            begin
                nn_next = opn_neg_reg;
                nm_next = PW'(opn_mag_reg);
                dn_next = opd_neg_reg;
                dm_next = PW'(opd_mag_reg);
            end
            fa_pkg::OP_OPER_WB:
            begin
                opn_mag_next = qn[WIDTH-1:0];
                opd_mag_next = qd[WIDTH-1:0];
            end
            fa_pkg::OP_FIN_EQ:
            begin
                nn_next = s_val[WIDTH];
                nm_next = PW'(s_mag);
                dn_next = d1_neg;
                dm_next = PW'(d1_mag);
            end
            fa_pkg::OP_MUL_A:  pa_next = mul_p;
            fa_pkg::OP_MUL_B:  pb_next = mul_p;
            fa_pkg::OP_MUL_DD:
            begin
                dm_next = mul_p;
                dn_next = d1_neg ^ opd_neg_reg;
            end
            fa_pkg::OP_SUM:
            begin
                if (neg_a == neg_b)
                begin
                    nm_next = pa_reg + pb_reg;
                    nn_next = neg_a;
                end
                else if (pa_reg >= pb_reg)
                begin
                    nm_next = pa_reg - pb_reg;
                    nn_next = neg_a;
                end
                else
                begin
                    nm_next = pb_reg - pa_reg;
                    nn_next = neg_b;
                end
            end
            fa_pkg::OP_MUL_NN:
            begin
                nm_next = mul_p;
                nn_next = n1_neg ^ opn_neg_reg;
            end
            fa_pkg::OP_MUL_ND:
            begin
                nm_next = mul_p;
                nn_next = n1_neg ^ opd_neg_reg;
            end
            fa_pkg::OP_MUL_DN:
            begin
                dm_next = mul_p;
                dn_next = d1_neg ^ opn_neg_reg;
            end
            fa_pkg::OP_FIN_Q:
            begin
                nm_next = qn;
                dm_next = qd;
            end
            fa_pkg::OP_COMMIT:
            begin
                if (fit_n && fit_d)
                begin
                    acc_num_next = nn_reg ? -nm_reg[WIDTH-1:0] : nm_reg[WIDTH-1:0];
                    acc_den_next = dn_reg ? -dm_reg[WIDTH-1:0] : dm_reg[WIDTH-1:0];
                    status_next  = fa_pkg::STAT_OK;
                end
                else
                begin
                    status_next = fa_pkg::STAT_OVF;
                end
                result_num_next = fa_pkg::FIELD_W'(acc_num_next);
                result_den_next = fa_pkg::FIELD_W'(acc_den_next);
                done_next       = 1'b1;
            end
            fa_pkg::OP_RECIP:
            begin
                acc_num_next    = acc_den_reg;
                acc_den_next    = acc_num_reg;
                result_num_next = fa_pkg::FIELD_W'(acc_den_reg);
                result_den_next = fa_pkg::FIELD_W'(acc_num_reg);
                status_next     = fa_pkg::STAT_OK;
                done_next       = 1'b1;
            end
            fa_pkg::OP_ZERO_ERR:
            begin
                result_num_next = fa_pkg::FIELD_W'(acc_num_reg);
                result_den_next = fa_pkg::FIELD_W'(acc_den_reg);
                status_next     = fa_pkg::STAT_ZERO;
                done_next       = 1'b1;
            end
            fa_pkg::OP_NOP_DONE:
            begin
                result_num_next = fa_pkg::FIELD_W'(acc_num_reg);
                result_den_next = fa_pkg::FIELD_W'(acc_den_reg);
                status_next     = fa_pkg::STAT_OK;
                done_next       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= WIDTH'(1);
            done_reg    <= 1'b0;
        end
        else
        begin
            acc_num_reg <= acc_num_next;
            acc_den_reg <= acc_den_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        opn_neg_reg    <= opn_neg_next;
        opn_mag_reg    <= opn_mag_next;
        opd_neg_reg    <= opd_neg_next;
        opd_mag_reg    <= opd_mag_next;
        nn_reg         <= nn_next;
        nm_reg         <= nm_next;
        dn_reg         <= dn_next;
        dm_reg         <= dm_next;
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        result_num_reg <= result_num_next;
        result_den_reg <= result_den_next;
        status_reg     <= status_next;
    end

    assign result_num = result_num_reg;
    assign result_den = result_den_reg;
    assign status     = status_reg;
    assign done       = done_reg;

    always_comb
    begin
        stat.cmd          = cmd_reg;
        stat.d2_zero      = (opd_mag_reg == '0);
        stat.n2_zero      = (opn_mag_reg == '0);
        stat.den_eq       = (d2s == acc_den_reg);
        stat.acc_num_zero = (acc_num_reg == '0);
        stat.gcd_done     = gcd_done;
        stat.div_done     = div_done & div_done_d;
    end

endmodule

### hw/rtl/fa_ctrl.sv
module fa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fa_pkg::dp_stat_t stat,
    output fa_pkg::op_t      op,
    output logic             busy
);

    fa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = fa_pkg::OP_NONE;
        case (state_reg)
            fa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op         = fa_pkg::OP_CAPTURE;
                    state_next = fa_pkg::S_CHECK;
                end
            end
            fa_pkg::S_CHECK:
            begin
                state_next = fa_pkg::S_IDLE;
                if (stat.cmd == fa_pkg::CMD_RECIP)
                begin
                    op = stat.acc_num_zero ? fa_pkg::OP_ZERO_ERR : fa_pkg::OP_RECIP;
                end
                else if (stat.cmd > fa_pkg::CMD_RECIP)
                begin
                    op = fa_pkg::OP_NOP_DONE;
                end
                else if (stat.d2_zero)
                begin
                    op = fa_pkg::OP_ZERO_ERR;
                end
                else
                begin
                    op         = fa_pkg::OP_FIN_OPER;
                    state_next = fa_pkg::S_RED_GSTART;
                end
            end
            fa_pkg::S_RED_GSTART:
            begin
                op         = fa_pkg::OP_GCD_START;
                state_next = fa_pkg::S_RED_GWAIT;
            end
            fa_pkg::S_RED_GWAIT:
            begin
                if (stat.gcd_done)
                begin
                    op         = fa_pkg::OP_DIV_START;
                    state_next = fa_pkg::S_RED_DWAIT;
                end
            end
            fa_pkg::S_RED_DWAIT:
            begin
                if (stat.div_done)
                begin
                    op         = fa_pkg::OP_OPER_WB;
                    state_next = fa_pkg::S_SETUP;
                end
            end
            fa_pkg::S_SETUP:
            begin
                case (stat.cmd)
                    fa_pkg::CMD_LOAD:
                    begin
                        op         = fa_pkg::OP_FIN_OPER;
                        state_next = fa_pkg::S_COMMIT;
                    end
                    fa_pkg::CMD_ADD, fa_pkg::CMD_SUB:
                    begin
                        if (stat.den_eq)
                        begin
                            op         = fa_pkg::OP_FIN_EQ;
                            state_next = fa_pkg::S_FIN_GSTART;
                        end
                        else
                        begin
                            op         = fa_pkg::OP_MUL_A;
                            state_next = fa_pkg::S_MUL_B;
                        end
                    end
                    fa_pkg::CMD_MUL:
                    begin
                        op         = fa_pkg::OP_MUL_NN;
                        state_next = fa_pkg::S_MUL_DD;
                    end
                    fa_pkg::CMD_DIV:
                    begin
                        if (stat.n2_zero)
                        begin
                            op         = fa_pkg::OP_ZERO_ERR;
                            state_next = fa_pkg::S_IDLE;
                        end
                        else
                        begin
                            op         = fa_pkg::OP_MUL_ND;
                            state_next = fa_pkg::S_MUL_DN;
                        end
                    end
                    default:
                    begin
                        op         = fa_pkg::OP_NOP_DONE;
                        state_next = fa_pkg::S_IDLE;
                    end
                endcase
            end
            fa_pkg::S_MUL_B:
            begin
                op         = fa_pkg::OP_MUL_B;
                state_next = fa_pkg::S_MUL_DD;
            end
            fa_pkg::S_MUL_DD:
            begin
                op = fa_pkg::OP_MUL_DD;
                if (stat.cmd == fa_pkg::CMD_MUL)
                begin
                    state_next = fa_pkg::S_FIN_GSTART;
                end
                else
                begin
                    state_next = fa_pkg::S_SUM;
                end
            end
            fa_pkg::S_SUM:
            begin
                op         = fa_pkg::OP_SUM;
                state_next = fa_pkg::S_FIN_GSTART;
            end
            fa_pkg::S_MUL_DN:
            begin
                op         = fa_pkg::OP_MUL_DN;
                state_next = fa_pkg::S_FIN_GSTART;
            end
            fa_pkg::S_FIN_GSTART:
            begin
                op         = fa_pkg::OP_GCD_START;
                state_next = fa_pkg::S_FIN_GWAIT;
            end
            fa_pkg::S_FIN_GWAIT:
            begin
                if (stat.gcd_done)
                begin
                    op         = fa_pkg::OP_DIV_START;
                    state_next = fa_pkg::S_FIN_DWAIT;
                end
            end
            fa_pkg::S_FIN_DWAIT:
            begin
                if (stat.div_done)
                begin
                    op         = fa_pkg::OP_FIN_Q;
                    state_next = fa_pkg::S_COMMIT;
                end
            end
            fa_pkg::S_COMMIT:
            begin
                op         = fa_pkg::OP_COMMIT;
                state_next = fa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != fa_pkg::S_IDLE);

endmodule

### hw/rtl/fraction_accumulator_alu.sv
// Fraction accumulator ALU: holds one signed fraction and applies load, add,
// subtract, multiply, divide and reciprocal commands to it.
// Input channel: a command transfer happens on a rising edge where start is
// high and busy is low; cmd, operand_num and operand_den are sampled there.
// Output channel: done is high for exactly one cycle per command, with
// result_num, result_den and status valid in that cycle. The receiver cannot
// stall, so the result must be taken in that cycle.
// Reciprocal, unused codes and zero-denominator errors raise done from the
// check state, with no gcd or divider run. Add, subtract, multiply and divide
// run a binary gcd and a pair of parallel 2*WIDTH-bit restoring dividers
// twice (operand reduction, then result reduction); load, and a divide by a
// zero fraction, stop after the first run. The run time is set by the gcd
// loop and the one-bit-per-cycle dividers. One command is in flight at a
// time; busy falls in the same cycle that done rises, so the next transfer
// may be taken then.
// Reset clears the accumulator to 0/1 and returns the controller to idle.
module fraction_accumulator_alu #(
    parameter int WIDTH = fa_pkg::WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fa_pkg::CMD_W-1:0]          cmd,
    input  logic signed [fa_pkg::FIELD_W-1:0] operand_num,
    input  logic signed [fa_pkg::FIELD_W-1:0] operand_den,
    output logic                              done,
    output logic signed [fa_pkg::FIELD_W-1:0] result_num,
    output logic signed [fa_pkg::FIELD_W-1:0] result_den,
    output logic [fa_pkg::STATUS_W-1:0]       status
);

    fa_pkg::op_t      op;
    fa_pkg::dp_stat_t stat;

    // The controller sequences one datapath operation per cycle.
    fa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    // The datapath holds the accumulator, the shared multiplier, the gcd
    // unit and the two dividers.
    fa_dp #(.WIDTH(WIDTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .cmd         (cmd),
        .operand_num (operand_num),
        .operand_den (operand_den),
        .result_num  (result_num),
        .result_den  (result_den),
        .status      (status),
        .done        (done),
        .stat        (stat)
    );

endmodule

### hw/rtl/fa_chk.sv
module fa_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [fa_pkg::STATUS_W-1:0]       status
);

    // A result only appears once the command is finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted command always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // Every command ends with a result: busy does not fall without done.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("undefined status code");

endmodule

bind fraction_accumulator_alu fa_chk u_fa_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status)
);

### dv/fa_checker.sv
module fa_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [fa_pkg::CMD_W-1:0]          cmd,
    input  logic signed [fa_pkg::FIELD_W-1:0] operand_num,
    input  logic signed [fa_pkg::FIELD_W-1:0] operand_den,
    input  logic                              done,
    input  logic signed [fa_pkg::FIELD_W-1:0] result_num,
    input  logic signed [fa_pkg::FIELD_W-1:0] result_den,
    input  logic [fa_pkg::STATUS_W-1:0]       status,
    output int                                errors,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [fa_pkg::FIELD_W-1:0] num;
        logic signed [fa_pkg::FIELD_W-1:0] den;
        fa_pkg::status_t                   st;
    } fraction_result_t;

    fraction_result_t expected_q[$];
    longint           frac_num;
    longint           frac_den;

    function automatic longint unsigned mag(input longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint unsigned gcd(input longint unsigned a, input longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Reduces a sign-magnitude fraction and stores it when both parts fit.
    function automatic fa_pkg::status_t reduce_store(input bit nn, input longint unsigned nm,
                                                     input bit dn, input longint unsigned dm);
        longint unsigned g;
        longint unsigned lim;
        g = gcd(nm, dm);
        lim = 64'd1 << (fa_pkg::FIELD_W - 1);
        if (g == 0)
            return fa_pkg::STAT_ZERO;
        nm = nm / g;
        dm = dm / g;
        if (nn ? nm > lim : nm >= lim)
            return fa_pkg::STAT_OVF;
        if (dn ? dm > lim : dm >= lim)
            return fa_pkg::STAT_OVF;
        frac_num = nn ? -longint'(nm) : longint'(nm);
        frac_den = dn ? -longint'(dm) : longint'(dm);
        return fa_pkg::STAT_OK;
    endfunction

    function automatic fa_pkg::status_t apply_command(input logic [fa_pkg::CMD_W-1:0] c,
                                                      input longint n2, input longint d2);
        longint          n1;
        longint          d1;
        longint          g;
        longint          on;
        longint          s;
        longint          a;
        longint          b;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        bit              neg;
        n1 = frac_num;
        d1 = frac_den;
        if (c == fa_pkg::CMD_RECIP)
        begin
            if (n1 == 0)
                return fa_pkg::STAT_ZERO;
            frac_num = d1;
            frac_den = n1;
            return fa_pkg::STAT_OK;
        end
        if (c > fa_pkg::CMD_DIV)
            return fa_pkg::STAT_OK;
        if (d2 == 0)
            return fa_pkg::STAT_ZERO;
        g = longint'(gcd(mag(n2), mag(d2)));
        n2 = n2 / g;
        d2 = d2 / g;
        case (c)
            fa_pkg::CMD_LOAD:
                return reduce_store(n2 < 0, mag(n2), d2 < 0, mag(d2));
            fa_pkg::CMD_ADD, fa_pkg::CMD_SUB:
            begin
                on = (c == fa_pkg::CMD_SUB) ? -n2 : n2;
                if (d1 == d2)
                begin
                    s = n1 + on;
                    return reduce_store(s < 0, mag(s), d1 < 0, mag(d1));
                end
                a = n1 * d2;
                b = on * d1;
                ma = mag(a);
                mb = mag(b);
                if ((a < 0) == (b < 0))
                begin
                    m = ma + mb;
                    neg = a < 0;
                end
                else if (ma >= mb)
                begin
                    m = ma - mb;
                    neg = a < 0;
                end
                else
                begin
                    m = mb - ma;
                    neg = b < 0;
                end
                return reduce_store(neg, m, (d1 < 0) != (d2 < 0), mag(d1) * mag(d2));
            end
            fa_pkg::CMD_MUL:
                return reduce_store((n1 < 0) != (n2 < 0), mag(n1) * mag(n2),
                                    (d1 < 0) != (d2 < 0), mag(d1) * mag(d2));
            default:
            begin
                if (n2 == 0)
                    return fa_pkg::STAT_ZERO;
                return reduce_store((n1 < 0) != (d2 < 0), mag(n1) * mag(d2),
                                    (d1 < 0) != (n2 < 0), mag(d1) * mag(n2));
            end
        endcase
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        fraction_result_t exp_r;
        if (!rst_n)
        begin
            frac_num = 0;
            frac_den = 1;
            errors = 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %0d/%0d status %0d",
                             $time, result_num, result_den, status);
                    errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result_num !== exp_r.num)
                    begin
                        $display("%0t: result_num expected %0d actual %0d",
                                 $time, exp_r.num, result_num);
                        errors++;
                    end
                    if (result_den !== exp_r.den)
                    begin
                        $display("%0t: result_den expected %0d actual %0d",
                                 $time, exp_r.den, result_den);
                        errors++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.st, status);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                exp_r.st = apply_command(cmd, longint'(operand_num), longint'(operand_den));
                exp_r.num = frac_num[fa_pkg::FIELD_W-1:0];
                exp_r.den = frac_den[fa_pkg::FIELD_W-1:0];
                expected_q.push_back(exp_r);
            end
        end
    end

endmodule

### dv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog allows a wide margin over the longest command.
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 600;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic [fa_pkg::CMD_W-1:0]          cmd = '0;
    logic signed [fa_pkg::FIELD_W-1:0] operand_num = '0;
    logic signed [fa_pkg::FIELD_W-1:0] operand_den = '0;
    logic                              busy;
    logic                              done;
    logic signed [fa_pkg::FIELD_W-1:0] result_num;
    logic signed [fa_pkg::FIELD_W-1:0] result_den;
    logic [fa_pkg::STATUS_W-1:0]       status;
    int                                errors;
    int                                pending;
    int                                idle_pct = 0;
    int                                quiet_cycles = 0;

    always #4 clk = ~clk;

    fraction_accumulator_alu i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .operand_num (operand_num),
        .operand_den (operand_den),
        .done        (done),
        .result_num  (result_num),
        .result_den  (result_den),
        .status      (status)
    );

    fa_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .operand_num (operand_num),
        .operand_den (operand_den),
        .done        (done),
        .result_num  (result_num),
        .result_den  (result_den),
        .status      (status),
        .errors      (errors),
        .pending     (pending)
    );

    // The watchdog counts cycles in which neither a command transfer nor a
    // result transfer happens, and gives up once the count gets too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Issues one command. All driving happens on the falling edge; since busy
    // is registered, seeing it low there means the next rising edge takes the
    // transfer. Start is dropped while the block is busy and raised for the next command.
    task automatic issue(input logic [fa_pkg::CMD_W-1:0] c,
                         input logic signed [fa_pkg::FIELD_W-1:0] n,
                         input logic signed [fa_pkg::FIELD_W-1:0] d);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        while (busy)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        cmd = c;
        operand_num = n;
        operand_den = d;
        @(negedge clk);
    endtask

    // Operand values lean toward small magnitudes so that chains of
    // arithmetic stay in range, with full-width values mixed in so that every
    // bit of both fields toggles and overflow is reached.
    function automatic logic signed [fa_pkg::FIELD_W-1:0] rand_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return $signed($urandom_range(40)) - 20;
        if (sel < 85)
            return $signed($urandom_range(4000)) - 2000;
        if (sel < 92)
            return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return $urandom;
    endfunction

    function automatic logic [fa_pkg::CMD_W-1:0] rand_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return fa_pkg::CMD_LOAD;
        if (sel < 96)
            return fa_pkg::CMD_W'($urandom_range(fa_pkg::CMD_ADD, fa_pkg::CMD_RECIP));
        return fa_pkg::CMD_W'($urandom_range(6, 7));
    endfunction

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: reciprocal of the reset value of zero, zero
        // denominators, divide by zero, sign handling with both parts
        // negative, equal denominators, overflow and the unused codes.
        issue(fa_pkg::CMD_RECIP, 5, 7);
        issue(fa_pkg::CMD_LOAD, 6, -4);
        issue(fa_pkg::CMD_ADD, 3, -2);
        issue(fa_pkg::CMD_SUB, -10, -6);
        issue(fa_pkg::CMD_MUL, -9, -12);
        issue(fa_pkg::CMD_DIV, -4, 6);
        issue(fa_pkg::CMD_RECIP, 0, 0);
        issue(fa_pkg::CMD_LOAD, 1, 0);
        issue(fa_pkg::CMD_ADD, 1, 0);
        issue(fa_pkg::CMD_SUB, 1, 0);
        issue(fa_pkg::CMD_MUL, 1, 0);
        issue(fa_pkg::CMD_DIV, 1, 0);
        issue(fa_pkg::CMD_DIV, 0, 5);
        issue(fa_pkg::CMD_LOAD, 32'sh8000_0000, -1);
        issue(fa_pkg::CMD_RECIP, 0, 0);
        issue(fa_pkg::CMD_LOAD, 32'sh8000_0000, 32'sh8000_0000);
        issue(fa_pkg::CMD_LOAD, 32'sh7fff_ffff, 1);
        issue(fa_pkg::CMD_MUL, 2, 1);
        issue(fa_pkg::CMD_ADD, 32'sh7fff_ffff, 1);
        issue(fa_pkg::CMD_LOAD, 32'sh8000_0000, 1);
        issue(fa_pkg::CMD_SUB, 1, 1);
        issue(fa_pkg::CMD_LOAD, 0, 3);
        issue(fa_pkg::CMD_RECIP, 0, 0);
        issue(3'd6, 32'sh7fff_ffff, 0);
        issue(3'd7, 32'sh8000_0000, 32'sh8000_0000);

        // Random part in four phases of sender idling: none, heavy, none
        // again (the receiver cannot stall, so its phase has no effect) and
        // moderate.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1:       idle_pct = 76;
                3:       idle_pct = 38;
                default: idle_pct = 0;
            endcase
            repeat (320)
                issue(rand_cmd(), rand_value(), rand_value());
        end
        start = 1'b0;

        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fa_pkg.sv
hw/rtl/fa_gcd.sv
hw/rtl/fa_div.sv
hw/rtl/fa_dp.sv
hw/rtl/fa_ctrl.sv
hw/rtl/fraction_accumulator_alu.sv
hw/rtl/fa_chk.sv
dv/fa_checker.sv
dv/tb.sv
